### sv/tce_pkg.sv
// Shared constants, types and control structs for the Takagi curve evaluator.
// Depends on nothing; tce_term_unit and takagi_curve_evaluator refer to it by scoped names.
package tce_pkg;

  localparam int MAX_TERMS   = 50;
  localparam int FRAC_BITS   = 32;
  localparam int WEIGHT_BITS = 16;

  localparam int SUM_BITS  = FRAC_BITS + 6;
  localparam int TRI_BITS  = FRAC_BITS + 1;
  localparam int TW_BITS   = WEIGHT_BITS + 1;
  localparam int TERM_BITS = TW_BITS + TRI_BITS - WEIGHT_BITS;
  localparam int K_BITS    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  localparam logic [K_BITS-1:0]      K_LAST       = K_BITS'(MAX_TERMS - 1);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(32768);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SUM,
    ST_HOLD
  } state_t;

  // Sequencer commands to the term unit
  typedef struct packed {
    logic start;
    logic step;
    logic sum;
  } ctrl_t;

  // Term unit status back to the sequencer
  typedef struct packed {
    logic tw_zero;
  } status_t;

endpackage

### sv/tce_cell.sv
// One bit cell of the abscissa shift row: loads, shifts left, folds by the MSB.
// Depends on nothing beyond its ports.
module tce_cell (
  input  logic clk,
  input  logic load,
  input  logic shift,
  input  logic load_bit,
  input  logic shift_in,
  input  logic fold,
  output logic q,
  output logic folded
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_bit;
    end else if (shift) begin
      q <= shift_in;
    end
  end

  // Upper half of the triangle uses the one's complement; the +1 comes later
  assign folded = q ^ fold;

endmodule

### sv/tce_term_unit.sv
// Weighted term unit: running weight, term product and accumulator.
// Depends on tce_pkg.
module tce_term_unit (
  input  logic                              clk,
  input  tce_pkg::ctrl_t                    ctrl,
  input  logic [tce_pkg::WEIGHT_BITS-1:0]   weight,
  input  logic [tce_pkg::TRI_BITS-1:0]      tri_val,
  output tce_pkg::status_t                  status,
  output logic [tce_pkg::SUM_BITS-1:0]      acc
);

  localparam int TPROD_BITS = tce_pkg::TW_BITS + tce_pkg::TRI_BITS;
  localparam int WPROD_BITS = tce_pkg::TW_BITS + tce_pkg::WEIGHT_BITS;

  logic [tce_pkg::TW_BITS-1:0]   tw;
  logic [tce_pkg::TERM_BITS-1:0] term;
  logic [TPROD_BITS-1:0]         term_prod;
  logic [WPROD_BITS-1:0]         tw_prod;
  logic [tce_pkg::TW_BITS-1:0]   tw_next;
  logic [tce_pkg::TERM_BITS-1:0] term_next;

  assign term_prod = TPROD_BITS'(tw) * TPROD_BITS'(tri_val);
  assign tw_prod   = WPROD_BITS'(tw) * WPROD_BITS'(weight);
  assign term_next = term_prod[TPROD_BITS-1:tce_pkg::WEIGHT_BITS];
  assign tw_next   = tw_prod[tce_pkg::TW_BITS+tce_pkg::WEIGHT_BITS-1:tce_pkg::WEIGHT_BITS];

  assign status.tw_zero = (tw_next == '0);

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      tw   <= {1'b1, {tce_pkg::WEIGHT_BITS{1'b0}}};
      term <= '0;
      acc  <= '0;
    end else if (ctrl.step) begin
      // term k is registered here and added to acc in the cycle after
      tw   <= tw_next;
      term <= term_next;
      acc  <= acc + tce_pkg::SUM_BITS'(term);
    end else if (ctrl.sum) begin
      term <= '0;
      acc  <= acc + tce_pkg::SUM_BITS'(term);
    end
  end

endmodule

### sv/takagi_curve_evaluator.sv
// Channel | Signals                                | Role
// in      | in_valid, in_stall, abscissa           | x as unsigned Q0.32
// out     | out_valid, out_stall, curve_value      | sum as unsigned Q6.32
// cfg     | cfg_wr_en, cfg_wr_data                 | weight w as unsigned Q0.16
// One transaction evaluates one term per step through the shared term multipliers, up to
// MAX_TERMS terms, fewer when the running weight underflows to zero.
// The row of bit cells shifts the abscissa left one place per term.
// rst is synchronous; it clears the sequencer, the output valid and sets weight to 0.5.
// A stalled result is held in the output register while the next abscissa is accepted.
// Depends on tce_pkg, tce_cell and tce_term_unit.
module takagi_curve_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] abscissa,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [37:0] curve_value,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  tce_pkg::state_t  state;
  tce_pkg::state_t  state_next;
  tce_pkg::ctrl_t   ctrl;
  tce_pkg::status_t status;

  logic [tce_pkg::K_BITS-1:0]      k;
  logic [tce_pkg::K_BITS-1:0]      k_next;
  logic [tce_pkg::WEIGHT_BITS-1:0] weight;
  logic [tce_pkg::FRAC_BITS-1:0]   bits;
  logic [tce_pkg::FRAC_BITS-1:0]   folded;
  logic [tce_pkg::FRAC_BITS-1:0]   mag;
  logic [tce_pkg::TRI_BITS-1:0]    tri_val;
  logic [tce_pkg::SUM_BITS-1:0]    acc;
  logic                            in_accept;
  logic                            out_free;
  logic                            out_load;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= tce_pkg::WEIGHT_RESET;
    end else if (cfg_wr_en) begin
      weight <= cfg_wr_data;
    end
  end

  // Abscissa shift row; bit 0 takes zero on each shift
  for (genvar i = 0; i < tce_pkg::FRAC_BITS; i++) begin : g_cell
    tce_cell u_cell (
      .clk      (clk),
      .load     (in_accept),
      .shift    (ctrl.step),
      .load_bit (abscissa[i]),
      .shift_in ((i == 0) ? 1'b0 : bits[(i == 0) ? 0 : i-1]),
      .fold     (bits[tce_pkg::FRAC_BITS-1]),
      .q        (bits[i]),
      .folded   (folded[i])
    );
  end

  assign mag     = folded + tce_pkg::FRAC_BITS'(bits[tce_pkg::FRAC_BITS-1]);
  assign tri_val = {mag, 1'b0};

  tce_term_unit u_term (
    .clk     (clk),
    .ctrl    (ctrl),
    .weight  (weight),
    .tri_val (tri_val),
    .status  (status),
    .acc     (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tce_pkg::ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    ctrl       = '0;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      tce_pkg::ST_IDLE: begin
        // hold off input while in reset
        in_stall = rst;
        if (in_valid) begin
          ctrl.start = 1'b1;
          k_next     = '0;
          state_next = tce_pkg::ST_RUN;
        end
      end
      tce_pkg::ST_RUN: begin
        ctrl.step = 1'b1;
        k_next    = k + 1'b1;
        if (status.tw_zero || k == tce_pkg::K_LAST) begin
          state_next = tce_pkg::ST_SUM;
        end
      end
      tce_pkg::ST_SUM: begin
        // fold in the last registered term
        ctrl.sum   = 1'b1;
        state_next = tce_pkg::ST_HOLD;
      end
      tce_pkg::ST_HOLD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = tce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tce_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      curve_value <= acc;
    end
  end

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == tce_pkg::ST_RUN && k == '0)
    else $error("accepted transaction did not start term loop");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    state == tce_pkg::ST_RUN |-> k <= tce_pkg::K_LAST)
    else $error("term counter beyond last term");

  a_sum_then_hold: assert property (@(posedge clk) disable iff (rst)
    state == tce_pkg::ST_SUM |=> state == tce_pkg::ST_HOLD)
    else $error("final sum step not followed by hold");

  a_hold_delivers: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && curve_value == $past(acc))
    else $error("result not presented after load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !out_load)
    else $error("stalled result overwritten");

endmodule
